[hdl/sfs_pkg.sv]
`timescale 1ns / 1ps
package sfs_pkg;

	localparam int TIME_BITS    = 16;
	localparam int OPACITY_BITS = 8;
	localparam int PROD_BITS    = TIME_BITS + OPACITY_BITS;
	localparam int QCNT_BITS    = (OPACITY_BITS > 1) ? $clog2(OPACITY_BITS) : 1;

	localparam logic [OPACITY_BITS-1:0] OPACITY_MAX = {OPACITY_BITS{1'b1}};

	localparam logic [1:0] ACT_BEGIN_OUT = 2'd0;
	localparam logic [1:0] ACT_BEGIN_IN  = 2'd1;
	localparam logic [1:0] ACT_CANCEL    = 2'd2;
	localparam logic [1:0] ACT_TICK      = 2'd3;

	localparam logic [1:0] STAGE_IDLE = 2'd0;
	localparam logic [1:0] STAGE_OUT  = 2'd1;
	localparam logic [1:0] STAGE_HOLD = 2'd2;
	localparam logic [1:0] STAGE_IN   = 2'd3;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] amount;
	} item_t;

	typedef struct packed {
		logic [7:0] opacity;
		logic [1:0] stage;
		logic       overlay_visible;
	} result_t;

endpackage

[hdl/screen_fade_sequencer.sv]
`timescale 1ns / 1ps
// Fade controller for a full-screen black overlay: idle, fading out, holding
// black, fading in. Every transfer in gives exactly one result. Begin, cancel
// and ticks outside a fade produce their result in the cycle after the transfer.
// A tick during a fade recomputes the opacity with a restoring divider that
// yields one quotient bit per cycle; item_stall stays high until the result of
// that item is registered. A result waiting at the output holds off the next
// transfer in until that result leaves.
module screen_fade_sequencer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  sfs_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output sfs_pkg::result_t result
);

	localparam logic [1:0] SQ_READY = 2'd0;
	localparam logic [1:0] SQ_DIV   = 2'd1;
	localparam logic [1:0] SQ_POST  = 2'd2;

	logic [1:0]                          seq_q;
	logic [1:0]                          stage_q;
	logic [sfs_pkg::TIME_BITS-1:0]       len_q;
	logic [sfs_pkg::TIME_BITS:0]         elapsed_q;
	logic [sfs_pkg::OPACITY_BITS-1:0]    level_q;
	logic                                fin_q;
	logic                                out_valid_q;
	sfs_pkg::result_t                    out_q;

	logic                                accept;
	logic                                out_free;
	logic                                out_set;
	logic [sfs_pkg::TIME_BITS-1:0]       amt;
	logic [sfs_pkg::TIME_BITS+1:0]       sum;
	logic [sfs_pkg::TIME_BITS:0]         el_next;
	logic                                fin;
	logic [sfs_pkg::TIME_BITS-1:0]       t_clip;
	logic                                fading;
	logic                                div_start;
	logic                                div_done;
	logic [sfs_pkg::OPACITY_BITS-1:0]    quo;
	logic [1:0]                          stage_n;
	logic [sfs_pkg::OPACITY_BITS-1:0]    level_n;
	logic [sfs_pkg::TIME_BITS-1:0]       len_n;
	logic [sfs_pkg::TIME_BITS:0]         el_n;
	logic [1:0]                          div_stage;
	logic [sfs_pkg::OPACITY_BITS-1:0]    div_level;

	assign out_free   = !out_valid_q || !result_stall;
	assign item_stall = (seq_q != SQ_READY) || (out_valid_q && result_stall);
	assign accept     = item_valid && !item_stall;

	assign amt     = sfs_pkg::TIME_BITS'(item.amount);
	assign sum     = {1'b0, elapsed_q} + {2'b00, amt};
	assign el_next = sum[sfs_pkg::TIME_BITS+1] ? {(sfs_pkg::TIME_BITS+1){1'b1}}
		: sum[sfs_pkg::TIME_BITS:0];
	assign fin     = el_next >= {1'b0, len_q};
	assign t_clip  = fin ? len_q : el_next[sfs_pkg::TIME_BITS-1:0];
	assign fading  = (stage_q == sfs_pkg::STAGE_OUT) || (stage_q == sfs_pkg::STAGE_IN);
	assign div_start = accept && (item.action == sfs_pkg::ACT_TICK) && fading;

	sfs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.num      (t_clip),
		.den      (len_q),
		.done     (div_done),
		.quotient (quo)
	);

	// next state for each accepted item; for a fade tick only the elapsed time
	always_comb begin
		stage_n = stage_q;
		level_n = level_q;
		len_n   = len_q;
		el_n    = elapsed_q;
		case (item.action)
			sfs_pkg::ACT_BEGIN_OUT: begin
				if (stage_q == sfs_pkg::STAGE_IDLE) begin
					if (amt == '0) begin
						stage_n = sfs_pkg::STAGE_HOLD;
						level_n = sfs_pkg::OPACITY_MAX;
					end else begin
						stage_n = sfs_pkg::STAGE_OUT;
						len_n   = amt;
						el_n    = '0;
						level_n = '0;
					end
				end
			end
			sfs_pkg::ACT_BEGIN_IN: begin
				if (stage_q == sfs_pkg::STAGE_HOLD) begin
					if (amt == '0) begin
						stage_n = sfs_pkg::STAGE_IDLE;
						level_n = '0;
					end else begin
						stage_n = sfs_pkg::STAGE_IN;
						len_n   = amt;
						el_n    = '0;
						level_n = sfs_pkg::OPACITY_MAX;
					end
				end
			end
			sfs_pkg::ACT_CANCEL: begin
				stage_n = sfs_pkg::STAGE_IDLE;
				el_n    = '0;
				level_n = '0;
			end
			default: begin
				if (fading)
					el_n = el_next;
			end
		endcase
	end

	// finish a fade tick from the quotient
	always_comb begin
		div_stage = stage_q;
		if (stage_q == sfs_pkg::STAGE_OUT) begin
			div_level = quo;
			if (fin_q)
				div_stage = sfs_pkg::STAGE_HOLD;
		end else begin
			div_level = sfs_pkg::OPACITY_MAX - quo;
			if (fin_q)
				div_stage = sfs_pkg::STAGE_IDLE;
		end
	end

	always_comb begin
		case (seq_q)
			SQ_READY: out_set = accept && !div_start;
			SQ_DIV:   out_set = div_done && out_free;
			SQ_POST:  out_set = out_free;
			default:  out_set = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q       <= SQ_READY;
			stage_q     <= sfs_pkg::STAGE_IDLE;
			len_q       <= '0;
			elapsed_q   <= '0;
			level_q     <= '0;
			fin_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_set || (out_valid_q && result_stall);
			case (seq_q)
				SQ_READY: begin
					if (accept) begin
						stage_q   <= stage_n;
						level_q   <= level_n;
						len_q     <= len_n;
						elapsed_q <= el_n;
						if (div_start) begin
							fin_q <= fin;
							seq_q <= SQ_DIV;
						end
					end
				end
				SQ_DIV: begin
					if (div_done) begin
						stage_q <= div_stage;
						level_q <= div_level;
						if (out_free) begin
							seq_q <= SQ_READY;
						end else begin
							seq_q <= SQ_POST;
						end
					end
				end
				SQ_POST: begin
					if (out_free) begin
						seq_q <= SQ_READY;
					end
				end
				default: seq_q <= SQ_READY;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (seq_q)
			SQ_READY: begin
				if (accept && !div_start) begin
					out_q.opacity         <= 8'(level_n);
					out_q.stage           <= stage_n;
					out_q.overlay_visible <= level_n != '0;
				end
			end
			SQ_DIV: begin
				if (div_done && out_free) begin
					out_q.opacity         <= 8'(div_level);
					out_q.stage           <= div_stage;
					out_q.overlay_visible <= div_level != '0;
				end
			end
			SQ_POST: begin
				if (out_free) begin
					out_q.opacity         <= 8'(level_q);
					out_q.stage           <= stage_q;
					out_q.overlay_visible <= level_q != '0;
				end
			end
			default: ;
		endcase
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> seq_q == SQ_DIV)
		else $error("divider finished outside a division");

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		stage_q == sfs_pkg::STAGE_IDLE |-> level_q == '0)
		else $error("idle stage with nonzero level");

	a_hold_full: assert property (@(posedge clk) disable iff (!arst_n)
		stage_q == sfs_pkg::STAGE_HOLD |-> level_q == sfs_pkg::OPACITY_MAX)
		else $error("hold stage without full level");

	a_tick_divides: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> seq_q == SQ_DIV && !result_valid || seq_q == SQ_DIV)
		else $error("fade tick did not start a division");

endmodule

[hdl/sfs_div.sv]
`timescale 1ns / 1ps
module sfs_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [sfs_pkg::TIME_BITS-1:0]       num,
	input  logic [sfs_pkg::TIME_BITS-1:0]       den,
	output logic                                done,
	output logic [sfs_pkg::OPACITY_BITS-1:0]    quotient
);

	logic                                 busy_q;
	logic [sfs_pkg::QCNT_BITS-1:0]        cnt_q;
	logic [sfs_pkg::PROD_BITS-1:0]        rem_q;
	logic [sfs_pkg::PROD_BITS-1:0]        dsh_q;
	logic [sfs_pkg::OPACITY_BITS-1:0]     quo_q;
	logic [sfs_pkg::PROD_BITS-1:0]        prod;
	logic                                 ge;

	// num * OMAX as a shift and subtract
	assign prod = {num, {sfs_pkg::OPACITY_BITS{1'b0}}}
		- {{sfs_pkg::OPACITY_BITS{1'b0}}, num};
	assign ge = rem_q >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= sfs_pkg::QCNT_BITS'(sfs_pkg::OPACITY_BITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= prod;
			dsh_q <= sfs_pkg::PROD_BITS'({den, {(sfs_pkg::OPACITY_BITS-1){1'b0}}});
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge)
				rem_q <= rem_q - dsh_q;
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[sfs_pkg::OPACITY_BITS-2:0], ge};
		end
	end

	assign quotient = quo_q;

endmodule

[dv/fade_check_pkg.sv]
`timescale 1ns / 1ps
package fade_check_pkg;

	import sfs_pkg::*;

	class overlay_scoreboard;
		logic [1:0]  stage;
		logic [15:0] fade_len;
		logic [16:0] elapsed_t;
		logic [7:0]  level;
		result_t     expected_overlay[$];
		int          errors;
		int          checked;
		int          fades_done;
		int          cancels;

		function new();
			stage       = STAGE_IDLE;
			fade_len    = '0;
			elapsed_t   = '0;
			level       = '0;
			errors      = 0;
			checked     = 0;
			fades_done  = 0;
			cancels     = 0;
		endfunction

		function logic [7:0] fraction();
			logic [16:0] t;
			logic [31:0] prod;
			if (fade_len == '0)
				return OPACITY_MAX;
			t = (elapsed_t > {1'b0, fade_len}) ? {1'b0, fade_len} : elapsed_t;
			prod = 32'(t) * 32'(OPACITY_MAX);
			return 8'(prod / 32'(fade_len));
		endfunction

		// Advance the fade state for one transfer in and queue its expected result; return 1 when it acted.
		function bit note_item(item_t it);
			bit          acted;
			logic [17:0] sum;
			result_t     exp;
			acted = 1'b0;
			case (it.action)
				ACT_BEGIN_OUT: if (stage == STAGE_IDLE) begin
					acted = 1'b1;
					if (it.amount == '0) begin
						stage = STAGE_HOLD;
						level = OPACITY_MAX;
					end else begin
						stage     = STAGE_OUT;
						fade_len  = it.amount;
						elapsed_t = '0;
						level     = '0;
					end
				end
				ACT_BEGIN_IN: if (stage == STAGE_HOLD) begin
					acted = 1'b1;
					if (it.amount == '0) begin
						stage = STAGE_IDLE;
						level = '0;
					end else begin
						stage     = STAGE_IN;
						fade_len  = it.amount;
						elapsed_t = '0;
						level     = OPACITY_MAX;
					end
				end
				ACT_CANCEL: begin
					acted     = 1'b1;
					cancels++;
					stage     = STAGE_IDLE;
					elapsed_t = '0;
					level     = '0;
				end
				default: if (stage == STAGE_OUT || stage == STAGE_IN) begin
					acted = 1'b1;
					sum = {1'b0, elapsed_t} + {2'b00, it.amount};
					elapsed_t = sum[17] ? 17'h1FFFF : sum[16:0];
					if (stage == STAGE_OUT) begin
						level = fraction();
						if (elapsed_t >= {1'b0, fade_len}) begin
							stage = STAGE_HOLD;
							fades_done++;
						end
					end else begin
						level = OPACITY_MAX - fraction();
						if (elapsed_t >= {1'b0, fade_len}) begin
							stage = STAGE_IDLE;
							fades_done++;
						end
					end
				end
			endcase
			exp.opacity         = level;
			exp.stage           = stage;
			exp.overlay_visible = (level != '0);
			expected_overlay.push_back(exp);
			return acted;
		endfunction

		function void check_result(result_t got);
			result_t exp;
			if (expected_overlay.size() == 0) begin
				errors++;
				$display("%0t: result with none expected: got %h", $time, got);
				return;
			end
			exp = expected_overlay.pop_front();
			checked++;
			if (got.opacity !== exp.opacity) begin
				errors++;
				$display("%0t: opacity expected %0d got %0d", $time, exp.opacity,
					got.opacity);
			end
			if (got.stage !== exp.stage) begin
				errors++;
				$display("%0t: stage expected %0d got %0d", $time, exp.stage, got.stage);
			end
			if (got.overlay_visible !== exp.overlay_visible) begin
				errors++;
				$display("%0t: overlay_visible expected %0b got %0b", $time,
					exp.overlay_visible, got.overlay_visible);
			end
		endfunction

		function int pending();
			return expected_overlay.size();
		endfunction
	endclass

endpackage

[dv/screen_fade_sequencer_tb.sv]
`timescale 1ns / 1ps
module screen_fade_sequencer_tb;

	import sfs_pkg::*;
	import fade_check_pkg::*;

	localparam int ITEM_TARGET = 1850;
	localparam int HANG_LIMIT  = 5000;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    result_valid;
	logic    result_stall;
	result_t result;

	overlay_scoreboard sb;
	int send_idle_pct  = 15;
	int recv_stall_pct = 53;
	int sent_items     = 0;
	int acted_items    = 0;
	int stuck_cycles   = 0;

	screen_fade_sequencer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_result(result);
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles == HANG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, HANG_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	task automatic send_cmd(input logic [1:0] act, input logic [15:0] amt);
		item_t it;
		it.action = act;
		it.amount = amt;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		if (sb.note_item(it))
			acted_items++;
		sent_items++;
	endtask

	function automatic logic [15:0] pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return '0;
		else if (r < 75)
			return 16'($urandom_range(1, 300));
		else if (r < 90)
			return 16'($urandom_range(1, 4095));
		return 16'($urandom_range(1, 65535));
	endfunction

	function automatic logic [15:0] pick_tick(input int len);
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return '0;
		else if (r < 75)
			return 16'($urandom_range(1, len / 4 + 1));
		else if (r < 92)
			return 16'($urandom_range(1, (len < 65535) ? len + 1 : 65535));
		return 16'($urandom_range(0, 65535));
	endfunction

	// Tick through one fade, with occasional cancels and stray transfers.
	task automatic run_fade(input logic [1:0] fade_stage, input int len);
		int n;
		int r;
		n = 0;
		while (sb.stage == fade_stage && n < 40) begin
			r = $urandom_range(0, 99);
			if (r < 3)
				send_cmd(ACT_CANCEL, 16'($urandom));
			else if (r < 8)
				send_cmd(2'($urandom), 16'($urandom));
			else
				send_cmd(ACT_TICK, pick_tick(len));
			n++;
		end
		if (sb.stage == fade_stage)
			send_cmd(ACT_CANCEL, 16'($urandom));
	endtask

	task automatic run_sequence();
		logic [15:0] len;
		len = pick_length();
		send_cmd(ACT_BEGIN_OUT, len);
		run_fade(STAGE_OUT, len);
		if (sb.stage == STAGE_HOLD && $urandom_range(0, 3) == 0)
			send_cmd(ACT_TICK, 16'($urandom));
		len = pick_length();
		send_cmd(ACT_BEGIN_IN, len);
		run_fade(STAGE_IN, len);
	endtask

	initial begin
		sb           = new();
		arst_n       <= 1'b0;
		item_valid   <= 1'b0;
		item         <= '0;
		result_stall <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_cmd(ACT_TICK, 16'hFFFF);
		send_cmd(ACT_BEGIN_IN, 16'h1234);
		send_cmd(ACT_CANCEL, 16'h0000);
		send_cmd(ACT_BEGIN_OUT, 16'h0000);
		send_cmd(ACT_BEGIN_OUT, 16'h0005);
		send_cmd(ACT_TICK, 16'hFFFF);
		send_cmd(ACT_BEGIN_IN, 16'h0000);
		send_cmd(ACT_BEGIN_OUT, 16'hFFFF);
		send_cmd(ACT_BEGIN_IN, 16'h0001);
		send_cmd(ACT_TICK, 16'h0000);
		send_cmd(ACT_TICK, 16'h7FFF);
		send_cmd(ACT_TICK, 16'hFFFF);
		send_cmd(ACT_BEGIN_IN, 16'h0003);
		send_cmd(ACT_BEGIN_OUT, 16'h0001);
		send_cmd(ACT_TICK, 16'h0001);
		send_cmd(ACT_TICK, 16'hFFFF);
		send_cmd(ACT_BEGIN_OUT, 16'h0001);
		send_cmd(ACT_TICK, 16'h0001);
		send_cmd(ACT_CANCEL, 16'hFFFF);
		send_cmd(ACT_BEGIN_OUT, 16'hAAAA);
		send_cmd(ACT_TICK, 16'h5555);
		send_cmd(ACT_CANCEL, 16'h0000);
		send_cmd(ACT_BEGIN_OUT, 16'h0000);
		send_cmd(ACT_BEGIN_IN, 16'h8000);
		send_cmd(ACT_CANCEL, 16'h0000);

		while (sent_items < ITEM_TARGET) begin
			if (sent_items < ITEM_TARGET / 3) begin
				send_idle_pct  = 15;
				recv_stall_pct = 53;
			end else if (sent_items < 2 * ITEM_TARGET / 3) begin
				send_idle_pct  = 53;
				recv_stall_pct = 15;
			end else begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			run_sequence();
		end
		item_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d transfers (%0d acted on), checked %0d results.",
			sent_items, acted_items, sb.checked);
		$display("Fades run to completion: %0d, cancels: %0d.", sb.fades_done, sb.cancels);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
